// ===== sv/wwkm_pkg.sv =====
// ----------------------------------------------------------------------------
// Whole-word keyword matcher package
// Shared constants, types and character helper functions.
// ----------------------------------------------------------------------------
package wwkm_pkg;

    localparam int MAX_KEY_LEN = 32;
    localparam int KEY_WORDS   = 4;
    localparam int LEN_W       = 6;
    localparam int POS_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [LEN_W-1:0] MAX_KEY_LEN_V = LEN_W'(MAX_KEY_LEN);
    localparam logic [POS_W-1:0] POS_MAX       = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_W3  = 3'd4;

    localparam logic [7:0] CHR_NUL        = 8'h00;
    localparam logic [7:0] CHR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHR_SPACE      = 8'h20;
    localparam logic [7:0] CHR_DASH       = 8'h2D;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;

    typedef logic [CFG_DATA_W-1:0] t_key_word;

    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data;
    } t_scan_step;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

// ===== sv/wwkm_scan.sv =====
// ----------------------------------------------------------------------------
// Whole-word keyword matcher line scanner
// Holds the per-line word tracking state and evaluates one byte per step.
// ----------------------------------------------------------------------------
module wwkm_scan
    import wwkm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_step       i_step,
    input  logic [LEN_W-1:0] i_key_len,
    input  t_key_word        i_key_words [KEY_WORDS],
    output logic             o_done,
    output logic             o_match
);

    logic             r_inside, n_inside;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_equal, n_equal;
    logic             r_found, n_found;
    logic             r_cut, n_cut;
    logic [7:0]       r_prev, n_prev;
    logic [7:0]       r_prev2, n_prev2;

    logic [7:0] key_byte;
    logic       key_ok;

    assign key_ok = (i_key_len != '0) && (i_key_len <= MAX_KEY_LEN_V);

    always_comb begin
        logic [7:0] c;
        logic [POS_W-1:0] p;
        c        = i_step.data;
        n_inside = r_inside;
        n_pos    = r_pos;
        n_equal  = r_equal;
        n_found  = r_found;
        n_cut    = r_cut;
        n_prev   = r_prev;
        n_prev2  = r_prev2;
        o_match  = 1'b0;
        key_byte = 8'h00;
        p        = '0;

        if (i_step.step) begin
            if (!r_cut) begin
                if (c == CHR_NUL || c == CHR_NEWLINE) begin
                    if (r_inside && r_equal && key_ok && r_pos == i_key_len) begin
                        n_found = 1'b1;
                    end
                    n_inside = 1'b0;
                    n_pos    = '0;
                    n_equal  = 1'b0;
                    n_cut    = 1'b1;
                end else if (r_inside) begin
                    if (is_alnum(c) || c == CHR_UNDERSCORE) begin
                        p = r_pos;
                        key_byte = i_key_words[p[4:3]][{p[2:0], 3'b000} +: 8];
                        if (p < i_key_len && !p[5]) begin
                            n_equal = r_equal && (fold_case(c) == fold_case(key_byte));
                        end else begin
                            n_equal = 1'b0;
                        end
                        if (p != POS_MAX) begin
                            n_pos = p + 1'b1;
                        end
                    end else begin
                        if (r_equal && key_ok && r_pos == i_key_len) begin
                            n_found = 1'b1;
                        end
                        n_inside = 1'b0;
                        n_pos    = '0;
                        n_equal  = 1'b0;
                    end
                end else if (is_alnum(c)) begin
                    key_byte = i_key_words[0][7:0];
                    n_inside = 1'b1;
                    n_equal  = (i_key_len != '0) && (fold_case(c) == fold_case(key_byte));
                    n_pos    = POS_W'(1);
                end
                if (!n_cut && c == CHR_SPACE && r_prev == CHR_DASH &&
                    r_prev2 == CHR_SPACE) begin
                    n_cut = 1'b1;
                end
            end
            n_prev2 = r_prev;
            n_prev  = c;

            if (i_step.last) begin
                if (!n_cut && n_inside && n_equal && key_ok && n_pos == i_key_len) begin
                    n_found = 1'b1;
                end
                o_match  = n_found;
                n_inside = 1'b0;
                n_pos    = '0;
                n_equal  = 1'b0;
                n_found  = 1'b0;
                n_cut    = 1'b0;
                n_prev   = 8'h00;
                n_prev2  = 8'h00;
            end
        end
    end

    assign o_done = i_step.step && i_step.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pos    <= '0;
            r_equal  <= 1'b0;
            r_found  <= 1'b0;
            r_cut    <= 1'b0;
            r_prev   <= 8'h00;
            r_prev2  <= 8'h00;
        end else begin
            r_inside <= n_inside;
            r_pos    <= n_pos;
            r_equal  <= n_equal;
            r_found  <= n_found;
            r_cut    <= n_cut;
            r_prev   <= n_prev;
            r_prev2  <= n_prev2;
        end
    end

    a_pos_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> r_inside)
        else $error("word position is set outside of a word");

    a_equal_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_equal |-> (r_inside && r_pos != '0))
        else $error("match flag is set without an open word");

    a_line_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!r_inside && !r_found && !r_cut && r_prev == 8'h00))
        else $error("line state did not clear after the last beat");

endmodule

// ===== sv/whole_word_keyword_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Whole-word keyword matcher
// Reports per text line whether the configured keyword occurs as a word.
// ----------------------------------------------------------------------------
// The slave stream carries one text byte per beat, with tlast on the last
// byte of a line. The master stream carries one beat per line, sent for the
// beat that had tlast set; bit 0 of its tdata is high when the keyword was
// found as a whole word, compared without regard to ASCII letter case.
// The keyword and its length are written through the configuration port, and
// the user must do so while no line is in flight; the block does not check.
// A length of zero never matches. A byte is registered on acceptance and then
// evaluated by the line scanner, whose result lands in the output register;
// a line result thus passes the input and output registers before it is sent.
// One byte is accepted every cycle when not stalled; the single scan step per
// byte sets the rate. While a result waits on the master side, bytes that are
// not the end of a line keep flowing; only a second line end stalls the slave
// side. Reset clears the keyword, the line state and the valid flags of both
// stream registers.
// ----------------------------------------------------------------------------
module whole_word_keyword_matcher_unit
    import wwkm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,   // line_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [0] line_matches, [7:1] zero
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    logic             r_out_match;
    logic [LEN_W-1:0] r_key_len;
    t_key_word        r_key_words [KEY_WORDS];

    logic       advance;
    t_scan_step scan_step;
    logic       scan_done;
    logic       scan_match;

    assign advance = !(r_in_valid && r_in_last && r_out_valid && !m_axis_tready);
    assign s_axis_tready = advance;

    assign scan_step.step = r_in_valid && advance;
    assign scan_step.last = r_in_last;
    assign scan_step.data = r_in_byte;

    wwkm_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (scan_step),
        .i_key_len   (r_key_len),
        .i_key_words (r_key_words),
        .o_done      (scan_done),
        .o_match     (scan_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_match <= 1'b0;
        end else if (scan_done) begin
            r_out_valid <= 1'b1;
            r_out_match <= scan_match;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_key_words[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LEN: r_key_len      <= i_cfg_data[LEN_W-1:0];
                CFG_KEY_W0:  r_key_words[0] <= i_cfg_data;
                CFG_KEY_W1:  r_key_words[1] <= i_cfg_data;
                CFG_KEY_W2:  r_key_words[2] <= i_cfg_data;
                CFG_KEY_W3:  r_key_words[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_match};

endmodule

// ===== tb/tb_whole_word_keyword_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Whole-word keyword matcher testbench
// Streams text lines, one byte per beat, through the matcher under a series of
// keyword settings and checks each per-line verdict against a scanner model
// kept inside the bench. Both stream sides idle at random, except in every fourth phase.
// ----------------------------------------------------------------------------
module tb_whole_word_keyword_matcher_unit;
    import wwkm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 125;
    localparam int PHASE_COUNT    = 14;

    typedef struct {
        logic [7:0] data;
        logic       eol;
    } t_text_beat;

    typedef enum int {FILL_WORD, FILL_ONES, FILL_ZERO, FILL_NUL} t_key_fill;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] text_byte
    logic                  s_axis_tlast = 1'b0; // line_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [0] line_matches, [7:1] zero
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    whole_word_keyword_matcher_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_text_beat  byte_q[$];
    logic [7:0]  line_buf[$];
    logic [7:0]  kw_text[$];
    bit          verdict_q[$];
    int          items_queued = 0;
    int          error_count = 0;
    bit          gaps_on = 1'b1;
    logic        in_fire = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    // Shadow of the keyword registers.
    logic [LEN_W-1:0]      key_len = '0;
    logic [CFG_DATA_W-1:0] key_regs[KEY_WORDS] = '{default: '0};

    // Line scanner state.
    bit              in_word;
    logic [POS_W-1:0] word_pos;
    bit              word_eq;
    bit              found;
    bit              cut_off;
    logic [7:0]      prev_byte;
    logic [7:0]      prev2_byte;

    function automatic bit is_word_lead(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] ascii_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] key_char(input logic [POS_W-1:0] p);
        return key_regs[p[4:3]][p[2:0]*8 +: 8];
    endfunction

    function automatic void clear_line();
        in_word = 1'b0;
        word_pos = '0;
        word_eq = 1'b0;
        found = 1'b0;
        cut_off = 1'b0;
        prev_byte = '0;
        prev2_byte = '0;
    endfunction

    function automatic void close_word();
        if (in_word && word_eq && key_len != 0 && key_len <= MAX_KEY_LEN &&
            word_pos == key_len) begin
            found = 1'b1;
        end
        in_word = 1'b0;
        word_pos = '0;
        word_eq = 1'b0;
    endfunction

    function automatic void extend_word(input logic [7:0] c);
        if (word_pos < key_len && word_pos < MAX_KEY_LEN) begin
            word_eq = word_eq && (ascii_lower(c) == ascii_lower(key_char(word_pos)));
        end else begin
            word_eq = 1'b0;
        end
        if (word_pos != POS_MAX) begin
            word_pos = word_pos + 1'b1;
        end
    endfunction

    function automatic void scan_text_byte(input logic [7:0] c, input logic eol,
                                           output bit has_verdict, output bit verdict);
        if (!cut_off) begin
            if (c == CHR_NUL || c == CHR_NEWLINE) begin
                close_word();
                cut_off = 1'b1;
            end else if (in_word) begin
                if (is_word_lead(c) || c == CHR_UNDERSCORE) begin
                    extend_word(c);
                end else begin
                    close_word();
                end
            end else if (is_word_lead(c)) begin
                in_word = 1'b1;
                word_pos = '0;
                word_eq = 1'b1;
                extend_word(c);
            end
            if (!cut_off && c == CHR_SPACE && prev_byte == CHR_DASH && prev2_byte == CHR_SPACE) begin
                cut_off = 1'b1;
            end
        end
        prev2_byte = prev_byte;
        prev_byte = c;
        has_verdict = eol;
        verdict = 1'b0;
        if (eol) begin
            if (!cut_off) begin
                close_word();
            end
            verdict = found;
            clear_line();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Result side: check each verdict beat, then feed accepted bytes to the scanner.
    always @(posedge i_clk) begin : watch_streams
        bit expected;
        bit has_verdict;
        bit verdict;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            clear_line();
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict beat 0x%02h with no line pending",
                                              m_axis_tdata));
                end else begin
                    expected = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== expected) begin
                        report_mismatch($sformatf("line_matches %b, expected %b",
                                                  m_axis_tdata[0], expected));
                    end
                    if (m_axis_tdata[7:1] !== 7'd0) begin
                        report_mismatch($sformatf("padding bits 0x%02h not zero",
                                                  m_axis_tdata[7:1]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scan_text_byte(s_axis_tdata, s_axis_tlast, has_verdict, verdict);
                if (has_verdict) begin
                    verdict_q.push_back(verdict);
                end
            end
        end
    end

    always @(negedge i_clk) begin : feed_bytes
        t_text_beat beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0 || byte_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end
            end else begin
                beat = byte_q.pop_front();
                s_axis_tdata <= beat.data;
                s_axis_tlast <= beat.eol;
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("whole_word_keyword_matcher_unit test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KEY_LEN: key_len = data[LEN_W-1:0];
            CFG_KEY_W0:  key_regs[0] = data;
            CFG_KEY_W1:  key_regs[1] = data;
            CFG_KEY_W2:  key_regs[2] = data;
            CFG_KEY_W3:  key_regs[3] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (byte_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 2 : 3);
        case (r)
            0: return 8'h30 + 8'($urandom_range(0, 9));
            1: return 8'h61 + 8'($urandom_range(0, 25));
            2: return 8'h41 + 8'($urandom_range(0, 25));
            default: return CHR_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endfunction

    function automatic void add_word(input int n);
        for (int i = 0; i < n; i++) begin
            line_buf.push_back(rand_word_char(i == 0));
        end
    endfunction

    function automatic void add_keyword(input bit mutate);
        logic [7:0] w[$];
        int k;
        if (kw_text.size() == 0) begin
            add_word($urandom_range(1, 6));
            return;
        end
        foreach (kw_text[i]) begin
            w.push_back(flip_case(kw_text[i]));
        end
        if (mutate) begin
            case ($urandom_range(0, 4))
                0: w.push_back(rand_word_char(1'b0));
                1: if (w.size() > 1) void'(w.pop_back());
                2: begin
                    k = $urandom_range(0, w.size() - 1);
                    w[k] = rand_word_char(k == 0);
                end
                3: w.push_front(CHR_UNDERSCORE);
                default: w.push_front(rand_word_char(1'b1));
            endcase
        end
        foreach (w[i]) begin
            line_buf.push_back(w[i]);
        end
    endfunction

    function automatic void add_separator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            line_buf.push_back(CHR_SPACE);
        end else if (r < 58) begin
            line_buf.push_back(CHR_DASH);
        end else if (r < 63) begin
            line_buf.push_back(CHR_UNDERSCORE);
        end else if (r < 80) begin
            case ($urandom_range(0, 5))
                0: line_buf.push_back(",");
                1: line_buf.push_back(".");
                2: line_buf.push_back("(");
                3: line_buf.push_back("/");
                4: line_buf.push_back(8'h09);
                default: line_buf.push_back(":");
            endcase
        end else begin
            line_buf.push_back(8'h80 + 8'($urandom_range(0, 127)));
        end
    endfunction

    function automatic void commit_line();
        foreach (line_buf[i]) begin
            byte_q.push_back('{data: line_buf[i], eol: (i == line_buf.size() - 1)});
        end
        items_queued += line_buf.size();
        line_buf.delete();
    endfunction

    function automatic void build_line();
        int r;
        int n;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    add_keyword(1'b0);
                end else if (r < 40) begin
                    add_keyword(1'b1);
                end else if (r < 58) begin
                    add_word($urandom_range(1, 10));
                end else if (r < 60) begin
                    add_word($urandom_range(64, 70));
                end else if (r < 85) begin
                    add_separator();
                end else if (r < 90) begin
                    add_str(" - ");
                end else if (r < 94) begin
                    line_buf.push_back($urandom_range(0, 1) ? CHR_NEWLINE : CHR_NUL);
                end else begin
                    line_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        commit_line();
    endfunction

    task automatic load_keyword(input int len, input t_key_fill fill);
        logic [CFG_DATA_W-1:0] w[KEY_WORDS];
        int n;
        for (int i = 0; i < KEY_WORDS; i++) begin
            case (fill)
                FILL_ONES: w[i] = '1;
                FILL_ZERO: w[i] = '0;
                default:   w[i] = {$urandom, $urandom};
            endcase
        end
        n = (len < MAX_KEY_LEN) ? len : MAX_KEY_LEN;
        if (fill == FILL_WORD || fill == FILL_NUL) begin
            for (int k = 0; k < n; k++) begin
                w[k / 8][(k % 8) * 8 +: 8] = rand_word_char(k == 0);
            end
        end
        if (fill == FILL_NUL && n > 0) begin
            w[(n / 2) / 8][((n / 2) % 8) * 8 +: 8] = CHR_NUL;
        end
        write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
        write_reg(CFG_KEY_W0, w[0]);
        write_reg(CFG_KEY_W1, w[1]);
        write_reg(CFG_KEY_W2, w[2]);
        write_reg(CFG_KEY_W3, w[3]);
        kw_text.delete();
        for (int k = 0; k < n; k++) begin
            kw_text.push_back(key_char(POS_W'(k)));
        end
    endtask

    initial begin : run_phases
        int          plan_len[8];
        t_key_fill   plan_fill[8];
        int          target;
        plan_len = '{0, 1, 32, 33, 63, 4, 8, 5};
        plan_fill = '{FILL_WORD, FILL_WORD, FILL_WORD, FILL_WORD,
                      FILL_WORD, FILL_NUL, FILL_ONES, FILL_ZERO};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines against the keyword "ab".
        write_reg(CFG_KEY_LEN, 64'd2);
        write_reg(CFG_KEY_W0, 64'h6261);
        write_reg(CFG_KEY_W1, '0);
        write_reg(CFG_KEY_W2, '0);
        write_reg(CFG_KEY_W3, '0);
        add_str("AB");
        commit_line();
        add_str("ab_");
        commit_line();
        line_buf.push_back(8'hFF);
        add_str("aB");
        line_buf.push_back(8'h80);
        commit_line();
        add_str("ab");
        line_buf.push_back(CHR_NEWLINE);
        add_str("x");
        commit_line();
        line_buf.push_back(CHR_NUL);
        add_str("ab");
        commit_line();
        add_str(" - ab");
        commit_line();
        add_str("a");
        commit_line();
        line_buf.push_back(8'hFF);
        commit_line();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            gaps_on = (ph % 4) != 3;
            if (ph < 8) begin
                load_keyword(plan_len[ph], plan_fill[ph]);
            end else begin
                load_keyword($urandom_range(1, 12), FILL_WORD);
            end
            target = items_queued + PHASE_BYTES;
            while (items_queued < target) begin
                build_line();
            end
        end

        settle();
        if (error_count == 0) begin
            $display("whole_word_keyword_matcher_unit test passed");
        end else begin
            $display("whole_word_keyword_matcher_unit test failed");
        end
        $finish;
    end

endmodule
